>>> hdl/sfd_pkg.sv
// Shared types and constants for the stuffed frame decoder.
`default_nettype none
package sfd_pkg;

  localparam logic [7:0] SYNC_MARK   = 8'hFF;
  localparam logic [7:0] ESCAPE_MARK = 8'hFE;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 18;
  localparam int LENGTH_W = 16;

  // default queue depths between the stages and at the output
  localparam int FRONT_DEPTH = 2;
  localparam int BACK_DEPTH  = 2;

  // configuration register indexes
  localparam int   CFG_IDX_W = 1;
  localparam logic REG_LENGTH_BYTES  = 1'b0;
  localparam logic REG_LENGTH_OFFSET = 1'b1;

  localparam logic [1:0] LENGTH_BYTES_TWO = 2'd2;

  typedef enum logic [1:0] {
    STATUS_BUSY  = 2'd0,
    STATUS_OK    = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  // classified input byte
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_sync;
    logic              is_escape;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    status_t           frame_status;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/sfd_queue.sv
// Small first-word-fall-through queue used between and after the decoder stages.
`default_nettype none
module sfd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule
`default_nettype wire

>>> hdl/sfd_front.sv
// Front stage: tags each received byte as sync, escape or plain and queues it.
`default_nettype none
module sfd_front #(
  parameter int DEPTH = sfd_pkg::FRONT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [sfd_pkg::BYTE_W-1:0] rx_byte,
  output logic                            full,
  input  wire logic                       item_pop,
  output sfd_pkg::item_t                  item,
  output logic                            item_empty
);

  localparam int ITEM_W = $bits(sfd_pkg::item_t);

  sfd_pkg::item_t    classified;
  logic [ITEM_W-1:0] q_rd;

  always_comb begin
    classified.data      = rx_byte;
    classified.is_sync   = (rx_byte == sfd_pkg::SYNC_MARK);
    classified.is_escape = (rx_byte == sfd_pkg::ESCAPE_MARK);
  end

  sfd_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(classified),
    .full   (full),
    .pop    (item_pop),
    .rd_data(q_rd),
    .empty  (item_empty)
  );

  assign item = sfd_pkg::item_t'(q_rd);

endmodule
`default_nettype wire

>>> hdl/sfd_back.sv
// Back stage: frame state, checksum, length count and result queue.
`default_nettype none
module sfd_back #(
  parameter int DEPTH = sfd_pkg::BACK_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    cfg_data,
  input  wire sfd_pkg::item_t                item,
  input  wire logic                          item_empty,
  output logic                               item_pop,
  input  wire logic                          pop,
  output sfd_pkg::result_t                   result,
  output logic                               empty
);

  localparam int RES_W = $bits(sfd_pkg::result_t);

  logic [1:0]                     length_bytes;
  logic [sfd_pkg::BYTE_W-1:0]     length_offset;

  logic                           after_sync, after_sync_next;
  logic                           in_frame, in_frame_next;
  logic                           await_length_high, await_length_high_next;
  logic [sfd_pkg::BYTE_W-1:0]     running_sum, running_sum_next;
  logic [sfd_pkg::COUNT_W-1:0]    byte_count, byte_count_next;
  logic [sfd_pkg::LENGTH_W-1:0]   frame_length, frame_length_next;

  logic                           out_full;
  logic                           fire;
  logic [sfd_pkg::BYTE_W-1:0]     d_byte;
  logic [sfd_pkg::BYTE_W-1:0]     sum_inc;
  logic [sfd_pkg::COUNT_W-1:0]    count_inc;
  logic [sfd_pkg::COUNT_W-1:0]    end_count;
  sfd_pkg::result_t               res;
  logic [RES_W-1:0]               q_rd;

  assign fire     = !item_empty && !out_full;
  assign item_pop = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_bytes  <= 2'd1;
      length_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::REG_LENGTH_BYTES:  length_bytes  <= cfg_data[1:0];
        sfd_pkg::REG_LENGTH_OFFSET: length_offset <= cfg_data;
        default:                    length_offset <= length_offset;
      endcase
    end
  end

  // escaped pair restores a 0xFF data byte
  assign d_byte    = (item.is_escape && after_sync) ? sfd_pkg::SYNC_MARK : item.data;
  assign count_inc = byte_count + 1'b1;
  assign end_count = sfd_pkg::COUNT_W'(frame_length) + sfd_pkg::COUNT_W'(length_offset)
                     + sfd_pkg::COUNT_W'(1);

  always_comb begin
    after_sync_next        = after_sync;
    in_frame_next          = in_frame;
    await_length_high_next = await_length_high;
    running_sum_next       = running_sum;
    byte_count_next        = byte_count;
    frame_length_next      = frame_length;
    sum_inc                = running_sum + d_byte;
    res.payload_byte       = '0;
    res.payload_valid      = 1'b0;
    res.frame_status       = sfd_pkg::STATUS_BUSY;

    if (await_length_high) begin
      // raw high length byte, no end check
      frame_length_next      = frame_length + {item.data, 8'h00};
      running_sum_next       = running_sum + item.data;
      byte_count_next        = count_inc;
      await_length_high_next = 1'b0;
    end else if (item.is_sync) begin
      after_sync_next = 1'b1;
    end else if (!item.is_escape && after_sync) begin
      // frame open, low length byte
      frame_length_next      = sfd_pkg::LENGTH_W'(item.data);
      running_sum_next       = item.data;
      byte_count_next        = sfd_pkg::COUNT_W'(1);
      after_sync_next        = 1'b0;
      in_frame_next          = 1'b1;
      await_length_high_next = (length_bytes == sfd_pkg::LENGTH_BYTES_TWO);
    end else begin
      if (item.is_escape && after_sync) begin
        after_sync_next = 1'b0;
      end
      if (!in_frame) begin
        res.frame_status       = sfd_pkg::STATUS_ERROR;
        after_sync_next        = 1'b0;
        in_frame_next          = 1'b0;
        await_length_high_next = 1'b0;
        running_sum_next       = '0;
        byte_count_next        = sfd_pkg::COUNT_W'(1);
      end else begin
        running_sum_next  = sum_inc;
        byte_count_next   = count_inc;
        res.payload_byte  = d_byte;
        res.payload_valid = 1'b1;
        if (count_inc == end_count) begin
          res.frame_status       = (sum_inc != '0) ? sfd_pkg::STATUS_ERROR
                                                   : sfd_pkg::STATUS_OK;
          after_sync_next        = 1'b0;
          in_frame_next          = 1'b0;
          await_length_high_next = 1'b0;
          running_sum_next       = '0;
          byte_count_next        = sfd_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_sync        <= 1'b0;
      in_frame          <= 1'b0;
      await_length_high <= 1'b0;
      running_sum       <= '0;
      byte_count        <= sfd_pkg::COUNT_W'(1);
      frame_length      <= '0;
    end else if (fire) begin
      after_sync        <= after_sync_next;
      in_frame          <= in_frame_next;
      await_length_high <= await_length_high_next;
      running_sum       <= running_sum_next;
      byte_count        <= byte_count_next;
      frame_length      <= frame_length_next;
    end
  end

  sfd_queue #(
    .WIDTH(RES_W),
    .DEPTH(DEPTH)
  ) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (fire),
    .wr_data(res),
    .full   (out_full),
    .pop    (pop),
    .rd_data(q_rd),
    .empty  (empty)
  );

  assign result = sfd_pkg::result_t'(q_rd);

  a_await_in_frame: assert property (@(posedge clk) disable iff (rst)
    await_length_high |-> in_frame) else $error("length high pending outside frame");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && (res.frame_status != sfd_pkg::STATUS_BUSY) |=> !in_frame && !after_sync)
    else $error("state not idle after frame end or error");

  a_sync_marks: assert property (@(posedge clk) disable iff (rst)
    fire && item.is_sync && !await_length_high |=> after_sync)
    else $error("sync byte not recorded");

endmodule
`default_nettype wire

>>> hdl/stuffed_frame_decoder.sv
// Top level of the byte-stuffed frame decoder with 8-bit sum check.
// Usage:
//   Input queue side: drive rx_byte and raise push; a transaction happens on a
//   clock edge with push high and full low. One raw link byte per transaction.
//   Result queue side: while empty is low the oldest result is on payload_byte,
//   payload_valid and frame_status; pop high with empty low takes it.
//   Every input byte gives exactly one result, in order.
//   Config: cfg_we with cfg_index 0 writes length_bytes, index 1 length_offset;
//   write only while no transaction is in flight.
// Path: a pushed byte is registered in the front queue, executed by the back
//   stage and registered in the result queue, then shows on the result ports.
// Throughput: one byte per cycle while the result queue has room; the per-byte
//   state update in the back stage (compare, 8-bit sum, 18-bit count compare) runs once per byte taken.
// Reset: rst (synchronous) empties both queues, clears frame state and loads
//   length_bytes 1, length_offset 0.
// Stall: if pop stays low the result queue fills, the back stage stops, then the
//   front queue fills and full rises; nothing is dropped.
`default_nettype none
module stuffed_frame_decoder #(
  parameter int FRONT_DEPTH = sfd_pkg::FRONT_DEPTH,
  parameter int BACK_DEPTH  = sfd_pkg::BACK_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [sfd_pkg::BYTE_W-1:0]         payload_byte,
  output logic                               payload_valid,
  output logic [1:0]                         frame_status,
  input  wire logic                          cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    cfg_data
);

  sfd_pkg::item_t   item;
  logic             item_empty;
  logic             item_pop;
  sfd_pkg::result_t result;

  sfd_front #(
    .DEPTH(FRONT_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .item_pop  (item_pop),
    .item      (item),
    .item_empty(item_empty)
  );

  sfd_back #(
    .DEPTH(BACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .item_empty(item_empty),
    .item_pop  (item_pop),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

  assign payload_byte  = result.payload_byte;
  assign payload_valid = result.payload_valid;
  assign frame_status  = result.frame_status;

endmodule
`default_nettype wire
